[sv/snfd_pkg.sv]
package snfd_pkg;

    localparam int MEM_BYTES_DEF    = 65536;
    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 4096;

    localparam logic [7:0] OP_WREN   = 8'h06;
    localparam logic [7:0] OP_RDSR   = 8'h05;
    localparam logic [7:0] OP_READ   = 8'h03;
    localparam logic [7:0] OP_PROG   = 8'h02;
    localparam logic [7:0] OP_SERASE = 8'h20;
    localparam logic [7:0] OP_CERASE = 8'hC7;
    localparam logic [7:0] OP_JEDEC  = 8'h9F;
    localparam logic [7:0] OP_RSTEN  = 8'h66;
    localparam logic [7:0] OP_RST    = 8'h99;
    localparam logic [7:0] BYTE_IDLE = 8'hFF;

    localparam logic [1:0] ACT_BYTE     = 2'd0;
    localparam logic [1:0] ACT_DESELECT = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;
    localparam logic [1:0] ACT_NONE     = 2'd3;

    localparam logic [1:0] REG_ID     = 2'd0;
    localparam logic [1:0] REG_PROG   = 2'd1;
    localparam logic [1:0] REG_SERASE = 2'd2;
    localparam logic [1:0] REG_CERASE = 2'd3;

    localparam logic [23:0] ID_RESET          = 24'hEF4016;
    localparam logic [15:0] PROG_TICKS_RESET  = 16'd3;
    localparam logic [15:0] SERASE_TICKS_RESET = 16'd45;
    localparam logic [31:0] CERASE_TICKS_RESET = 32'd25000;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] mosi_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] miso_byte;
        logic       busy_res;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_ERASE,
        ST_OUT
    } state_t;

endpackage

[sv/snfd_ram.sv]
module snfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/spi_nor_flash_device_top.sv]
// A result is offered in ST_OUT after its word is accepted; read data and page
// program bytes pass through ST_READ or ST_WRITE first (for a program byte,
// memory read, then AND write-back), and an erase through the ST_ERASE sweep of
// its sector or of the whole array. No new word is accepted until the result is
// taken. Erase sweeps one byte per cycle. After reset a clearing pass fills the
// array with 0xFF; no word is accepted meanwhile. Configuration writes are taken at any time.
module spi_nor_flash_device_top #(
    parameter int MEM_BYTES    = snfd_pkg::MEM_BYTES_DEF,
    parameter int PAGE_BYTES   = snfd_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = snfd_pkg::SECTOR_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  snfd_pkg::in_word_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output snfd_pkg::out_word_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);

    logic [23:0] id_reg;
    logic [15:0] prog_ticks_reg;
    logic [15:0] serase_ticks_reg;
    logic [31:0] cerase_ticks_reg;

    snfd_pkg::state_t state_reg, state_next;
    logic [7:0]  op_reg, op_next;
    logic [2:0]  phase_reg, phase_next;
    logic [23:0] addr_reg, addr_next;
    logic        wel_reg, wel_next;
    logic        armed_reg, armed_next;
    logic        pend_reg, pend_next;
    logic [31:0] busy_reg, busy_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [AW-1:0] sweep_end_reg, sweep_end_next;
    logic [7:0]  mosi_reg, mosi_next;
    logic [7:0]  miso_reg, miso_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    rdata;
    logic [AW-1:0] mem_addr;
    logic [AW-1:0] page_next;
    logic          accept;

    assign pready = 1'b1;
    assign mem_addr = addr_reg[AW-1:0];
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != snfd_pkg::ST_IDLE);
    assign out_valid = (state_reg == snfd_pkg::ST_OUT);
    assign out_data.miso_byte = miso_reg;
    assign out_data.busy_res = (busy_reg != 32'd0);

    always_comb
    begin
        page_next = mem_addr;
        page_next[PW-1:0] = mem_addr[PW-1:0] + 1'b1;
    end

    always_comb
    begin
        unique case (paddr[3:2])
            snfd_pkg::REG_ID:     prdata = {8'd0, id_reg};
            snfd_pkg::REG_PROG:   prdata = {16'd0, prog_ticks_reg};
            snfd_pkg::REG_SERASE: prdata = {16'd0, serase_ticks_reg};
            default:              prdata = cerase_ticks_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg           <= snfd_pkg::ID_RESET;
            prog_ticks_reg   <= snfd_pkg::PROG_TICKS_RESET;
            serase_ticks_reg <= snfd_pkg::SERASE_TICKS_RESET;
            cerase_ticks_reg <= snfd_pkg::CERASE_TICKS_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            unique case (paddr[3:2])
                snfd_pkg::REG_ID:     id_reg <= pwdata[23:0];
                snfd_pkg::REG_PROG:   prog_ticks_reg <= pwdata[15:0];
                snfd_pkg::REG_SERASE: serase_ticks_reg <= pwdata[15:0];
                default:              cerase_ticks_reg <= pwdata;
            endcase
        end
    end

    snfd_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_array (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (mem_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        we    = 1'b0;
        waddr = sweep_reg;
        wdata = snfd_pkg::BYTE_IDLE;
        unique case (state_reg)
            snfd_pkg::ST_CLEAR, snfd_pkg::ST_ERASE: we = 1'b1;
            snfd_pkg::ST_WRITE:
            begin
                we    = 1'b1;
                waddr = mem_addr;
                wdata = rdata & mosi_reg;
            end
            default: we = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        phase_next     = phase_reg;
        addr_next      = addr_reg;
        wel_next       = wel_reg;
        armed_next     = armed_reg;
        pend_next      = pend_reg;
        busy_next      = busy_reg;
        sweep_next     = sweep_reg;
        sweep_end_next = sweep_end_reg;
        mosi_next      = mosi_reg;
        miso_next      = miso_reg;
        unique case (state_reg)
            snfd_pkg::ST_CLEAR, snfd_pkg::ST_ERASE:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == sweep_end_reg)
                begin
                    state_next = (state_reg == snfd_pkg::ST_CLEAR) ?
                        snfd_pkg::ST_IDLE : snfd_pkg::ST_OUT;
                end
            end
            snfd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    miso_next  = snfd_pkg::BYTE_IDLE;
                    mosi_next  = in_data.mosi_byte;
                    state_next = snfd_pkg::ST_OUT;
                    if (in_data.action == snfd_pkg::ACT_BYTE)
                    begin
                        if (phase_reg != 3'd7)
                        begin
                            phase_next = phase_reg + 3'd1;
                        end
                        if (phase_reg == 3'd0)
                        begin
                            op_next   = (busy_reg != 32'd0 &&
                                         in_data.mosi_byte != snfd_pkg::OP_RDSR) ?
                                        8'd0 : in_data.mosi_byte;
                            addr_next = 24'd0;
                            pend_next = 1'b0;
                        end
                        else if (op_reg == snfd_pkg::OP_RDSR)
                        begin
                            miso_next = {6'd0, wel_reg, busy_reg != 32'd0};
                        end
                        else if (op_reg == snfd_pkg::OP_JEDEC)
                        begin
                            if (phase_reg == 3'd1) miso_next = id_reg[23:16];
                            else if (phase_reg == 3'd2) miso_next = id_reg[15:8];
                            else if (phase_reg == 3'd3) miso_next = id_reg[7:0];
                        end
                        else if (op_reg == snfd_pkg::OP_READ ||
                                 op_reg == snfd_pkg::OP_PROG ||
                                 op_reg == snfd_pkg::OP_SERASE)
                        begin
                            if (phase_reg <= 3'd3)
                            begin
                                addr_next = {addr_reg[15:0], in_data.mosi_byte};
                                if (phase_reg == 3'd3)
                                begin
                                    addr_next = 24'(addr_next[AW-1:0]);
                                end
                            end
                            else if (op_reg == snfd_pkg::OP_READ)
                            begin
                                state_next = snfd_pkg::ST_READ;
                            end
                            else if (op_reg == snfd_pkg::OP_PROG && wel_reg)
                            begin
                                state_next = snfd_pkg::ST_WRITE;
                            end
                        end
                    end
                    else if (in_data.action == snfd_pkg::ACT_DESELECT)
                    begin
                        if (phase_reg != 3'd0)
                        begin
                            if (op_reg == snfd_pkg::OP_WREN && phase_reg == 3'd1)
                            begin
                                wel_next = 1'b1;
                            end
                            else if (op_reg == snfd_pkg::OP_SERASE &&
                                     phase_reg == 3'd4 && wel_reg)
                            begin
                                sweep_next     = {mem_addr[AW-1:SW], SW'(0)};
                                sweep_end_next = {mem_addr[AW-1:SW], {SW{1'b1}}};
                                wel_next       = 1'b0;
                                busy_next      = {16'd0, serase_ticks_reg};
                                state_next     = snfd_pkg::ST_ERASE;
                            end
                            else if (op_reg == snfd_pkg::OP_CERASE &&
                                     phase_reg == 3'd1 && wel_reg)
                            begin
                                sweep_next     = '0;
                                sweep_end_next = '1;
                                wel_next       = 1'b0;
                                busy_next      = cerase_ticks_reg;
                                state_next     = snfd_pkg::ST_ERASE;
                            end
                            else if (op_reg == snfd_pkg::OP_PROG && pend_reg)
                            begin
                                wel_next  = 1'b0;
                                busy_next = {16'd0, prog_ticks_reg};
                            end
                            else if (op_reg == snfd_pkg::OP_RST &&
                                     phase_reg == 3'd1 && armed_reg)
                            begin
                                wel_next  = 1'b0;
                                addr_next = 24'd0;
                            end
                            armed_next = (op_reg == snfd_pkg::OP_RSTEN &&
                                          phase_reg == 3'd1);
                        end
                        phase_next = 3'd0;
                        pend_next  = 1'b0;
                    end
                    else if (in_data.action == snfd_pkg::ACT_TICK)
                    begin
                        if (busy_reg != 32'd0)
                        begin
                            busy_next = busy_reg - 32'd1;
                        end
                    end
                end
            end
            snfd_pkg::ST_READ:
            begin
                miso_next  = rdata;
                addr_next  = 24'(mem_addr + 1'b1);
                state_next = snfd_pkg::ST_OUT;
            end
            snfd_pkg::ST_WRITE:
            begin
                pend_next  = 1'b1;
                addr_next  = 24'(page_next);
                state_next = snfd_pkg::ST_OUT;
            end
            snfd_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = snfd_pkg::ST_IDLE;
                end
            end
            default: state_next = snfd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= snfd_pkg::ST_CLEAR;
            op_reg        <= 8'd0;
            phase_reg     <= 3'd0;
            addr_reg      <= 24'd0;
            wel_reg       <= 1'b0;
            armed_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            busy_reg      <= 32'd0;
            sweep_reg     <= '0;
            sweep_end_reg <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            addr_reg      <= addr_next;
            wel_reg       <= wel_next;
            armed_reg     <= armed_next;
            pend_reg      <= pend_next;
            busy_reg      <= busy_next;
            sweep_reg     <= sweep_next;
            sweep_end_reg <= sweep_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mosi_reg <= mosi_next;
        miso_reg <= miso_next;
    end

endmodule
